@@ rtl/core/egmh_pkg.sv @@
// package: widths, codes and node type for the epsilon-greedy min-heap
package egmh_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W        = 25;
  localparam int unsigned ORD_W        = 32;
  localparam int unsigned PL_W         = 32;
  localparam int unsigned EPS_W        = 17;
  localparam int unsigned OCC_W        = 11;

  localparam logic [EPS_W-1:0] EPS_RESET = 17'd13107;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  // unassigned op code, completes with no effect
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ORD_W-1:0] order;
    logic [PL_W-1:0]  payload;
  } node_t;

endpackage

@@ rtl/core/epsilon_greedy_min_heap.sv @@
// top level: epsilon-greedy binary min-heap with one node memory and a sift sequencer
//
//  channel   ports                                   transfer
//  command   start_i, op_i .. rand_pos_i, busy_o     start_i && !busy_o
//  config    cfg_we_i, cfg_wdata_i                   cfg_we_i
//  result    result_valid_o, removed_valid_o ..      result_valid_o (one cycle)
//
// insert: per level climbed, read the parent, then compare and write; stop at the root or
// at a parent not sorting after it. remove: read the root, stop if the queue empties, else
// move the last node to the root and sift down, reading the children per level. a random
// pick first zeroes the picked node's key and climbs it. one node memory read port serves
// all steps. clear and flagged commands stay in idle. async active-low reset empties the
// queue; node memory is not cleared. the receiver cannot stall results.
module epsilon_greedy_min_heap
  import egmh_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [23:0]      heuristic_value_i,
  input  logic [31:0]      payload_i,
  input  logic [15:0]      rand_draw_i,
  input  logic [15:0]      rand_pos_i,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_wdata_i,
  output logic             result_valid_o,
  output logic             removed_valid_o,
  output logic [31:0]      removed_payload_o,
  output logic             was_random_o,
  output logic [OCC_W-1:0] occupancy_o,
  output logic [1:0]       status_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned PW = 16 + CW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_CHK   = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_RND_MUL  = 4'd3;
  localparam logic [3:0] S_RND_LD   = 4'd4;
  localparam logic [3:0] S_POP_RD   = 4'd5;
  localparam logic [3:0] S_POP_ROOT = 4'd6;
  localparam logic [3:0] S_POP_LAST = 4'd7;
  localparam logic [3:0] S_DN_CHK   = 4'd8;
  localparam logic [3:0] S_DN_L     = 4'd9;
  localparam logic [3:0] S_DN_R     = 4'd10;
  localparam logic [3:0] S_DN_CMP   = 4'd11;

  node_t mem [CAPACITY];
  node_t rd_q;

  logic [3:0]       state_q, state_d;
  logic [AW-1:0]    pos_q, pos_d, bpos_q, bpos_d;
  node_t            node_q, node_d, best_q, best_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [ORD_W-1:0] ctr_q, ctr_d;
  logic [EPS_W-1:0] eps_q;
  logic [15:0]      rpos_q, rpos_d;
  logic             strobe_q, strobe_d, rv_q, rv_d, rnd_q, rnd_d;
  logic [PL_W-1:0]  rem_q, rem_d;
  logic [1:0]       st_q, st_d;

  logic             we_c;
  logic [AW-1:0]    waddr_c, raddr_c;
  node_t            wdata_c;

  // shared ordering comparator: a sorts strictly after b
  node_t            cmp_a, cmp_b;
  logic             a_after_b;
  assign a_after_b = {cmp_a.key, cmp_a.order} > {cmp_b.key, cmp_b.order};

  logic [LW-1:0]    left_c, right_c, cnt_ext;
  logic [AW-1:0]    parent_c;
  logic [PW-1:0]    prod_c;
  logic [CW-1:0]    pick_c;

  assign cnt_ext  = LW'(cnt_q);
  assign left_c   = {1'b0, pos_q, 1'b1};
  assign right_c  = left_c + LW'(1);
  assign parent_c = AW'((pos_q - AW'(1)) >> 1);
  assign prod_c   = PW'(rpos_q) * PW'(cnt_q);

  always_comb begin
    pick_c = prod_c[PW-1:16];
    if (pick_c >= cnt_q) begin
      pick_c = cnt_q - CW'(1);
    end
  end

  always_comb begin
    cmp_a = node_q;
    cmp_b = best_q;
    case (state_q)
      S_UP_CMP: begin
        if (rnd_q) begin
          cmp_a = node_q;
          cmp_b = rd_q;
        end else begin
          cmp_a = rd_q;
          cmp_b = node_q;
        end
      end
      S_DN_R: begin
        cmp_a = best_q;
        cmp_b = rd_q;
      end
      default: begin
        cmp_a = node_q;
        cmp_b = best_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    bpos_d   = bpos_q;
    node_d   = node_q;
    best_d   = best_q;
    cnt_d    = cnt_q;
    ctr_d    = ctr_q;
    rpos_d   = rpos_q;
    strobe_d = 1'b0;
    rv_d     = rv_q;
    rnd_d    = rnd_q;
    rem_d    = rem_q;
    st_d     = st_q;
    we_c     = 1'b0;
    waddr_c  = pos_q;
    wdata_c  = node_q;
    raddr_c  = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rv_d   = 1'b0;
          rnd_d  = 1'b0;
          rem_d  = '0;
          st_d   = ST_OK;
          rpos_d = rand_pos_i;
          case (op_i)
            OP_INSERT: begin
              if (cnt_q >= CW'(CAPACITY)) begin
                st_d     = ST_FULL;
                strobe_d = 1'b1;
              end else begin
                node_d  = '{key: {1'b0, heuristic_value_i} + KEY_W'(1),
                            order: ctr_q, payload: payload_i};
                pos_d   = AW'(cnt_q);
                ctr_d   = ctr_q + ORD_W'(1);
                cnt_d   = cnt_q + CW'(1);
                state_d = S_UP_CHK;
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                st_d     = ST_EMPTY;
                strobe_d = 1'b1;
              end else if ({1'b0, rand_draw_i} < eps_q) begin
                rnd_d   = 1'b1;
                state_d = S_RND_MUL;
              end else begin
                state_d = S_POP_RD;
              end
            end
            OP_CLEAR: begin
              cnt_d    = '0;
              ctr_d    = '0;
              strobe_d = 1'b1;
            end
            default: strobe_d = 1'b1;
          endcase
        end
      end
      S_UP_CHK: begin
        if (pos_q == '0) begin
          we_c = 1'b1;
          if (rnd_q) begin
            state_d = S_POP_RD;
          end else begin
            strobe_d = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          raddr_c = parent_c;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // insert moves on a strictly greater parent; the forced key moves unless greater
        if (a_after_b ^ rnd_q) begin
          we_c    = 1'b1;
          wdata_c = rd_q;
          pos_d   = parent_c;
          state_d = S_UP_CHK;
        end else begin
          we_c = 1'b1;
          if (rnd_q) begin
            state_d = S_POP_RD;
          end else begin
            strobe_d = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end
      S_RND_MUL: begin
        pos_d   = AW'(pick_c);
        raddr_c = AW'(pick_c);
        state_d = S_RND_LD;
      end
      S_RND_LD: begin
        node_d  = '{key: '0, order: rd_q.order, payload: rd_q.payload};
        state_d = S_UP_CHK;
      end
      S_POP_RD: begin
        raddr_c = '0;
        state_d = S_POP_ROOT;
      end
      S_POP_ROOT: begin
        rv_d  = 1'b1;
        rem_d = rd_q.payload;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          raddr_c = AW'(cnt_q - CW'(1));
          state_d = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        node_d  = rd_q;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_c >= cnt_ext) begin
          we_c     = 1'b1;
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          raddr_c = AW'(left_c);
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        best_d = rd_q;
        bpos_d = AW'(left_c);
        if (right_c < cnt_ext) begin
          raddr_c = AW'(right_c);
          state_d = S_DN_R;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_R: begin
        // right child wins only when strictly smaller than the left
        if (a_after_b) begin
          best_d = rd_q;
          bpos_d = AW'(right_c);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (a_after_b) begin
          we_c    = 1'b1;
          wdata_c = best_q;
          pos_d   = bpos_q;
          state_d = S_DN_CHK;
        end else begin
          we_c     = 1'b1;
          strobe_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rd_q <= mem[raddr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ctr_q    <= '0;
      eps_q    <= EPS_RESET;
      strobe_q <= 1'b0;
      rv_q     <= 1'b0;
      rnd_q    <= 1'b0;
      st_q     <= ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ctr_q    <= ctr_d;
      strobe_q <= strobe_d;
      rv_q     <= rv_d;
      rnd_q    <= rnd_d;
      st_q     <= st_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    bpos_q <= bpos_d;
    node_q <= node_d;
    best_q <= best_d;
    rpos_q <= rpos_d;
    rem_q  <= rem_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign result_valid_o    = strobe_q;
  assign removed_valid_o   = rv_q;
  assign removed_payload_o = rem_q;
  assign was_random_o      = rnd_q;
  assign occupancy_o       = OCC_W'(cnt_q);
  assign status_o          = st_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (state_q == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == OP_INSERT && cnt_q < CW'(CAPACITY)) |=> busy_o)
    else $error("insert did not start a sift");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && rv_q) |-> (st_q == ST_OK))
    else $error("removed entry flagged with error status");

endmodule

@@ sim/egmh_checker.sv @@
// checker: predicts heap results from observed command transfers and compares them
`timescale 1ns / 1ps
module egmh_checker
  import egmh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       op_i,
  input  logic [23:0]      heuristic_value_i,
  input  logic [31:0]      payload_i,
  input  logic [15:0]      rand_draw_i,
  input  logic [15:0]      rand_pos_i,
  input  logic             cfg_we_i,
  input  logic [EPS_W-1:0] cfg_wdata_i,
  input  logic             result_valid_i,
  input  logic             removed_valid_i,
  input  logic [31:0]      removed_payload_i,
  input  logic             was_random_i,
  input  logic [OCC_W-1:0] occupancy_i,
  input  logic [1:0]       status_i,
  output int               errors_o,
  output int               pending_o,
  output int               removals_o,
  output int               random_removals_o
);

  typedef struct packed {
    logic             rvalid;
    logic [31:0]      rpayload;
    logic             rnd;
    logic [OCC_W-1:0] occ;
    logic [1:0]       status;
  } outcome_t;

  node_t            heap_q [CAPACITY_DEF];
  int unsigned      count_q;
  logic [ORD_W-1:0] seq_q;
  logic [EPS_W-1:0] eps_q;
  outcome_t         outcome_fifo[$];

  // a sorts strictly after b
  function automatic bit later(int unsigned a, int unsigned b);
    if (heap_q[a].key != heap_q[b].key) return heap_q[a].key > heap_q[b].key;
    return heap_q[a].order > heap_q[b].order;
  endfunction

  function automatic void swap_at(int unsigned a, int unsigned b);
    node_t t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endfunction

  function automatic outcome_t predict_heap_op(logic [1:0] op, logic [23:0] hv,
                                               logic [31:0] pl, logic [15:0] draw,
                                               logic [15:0] rpos);
    outcome_t o;
    int unsigned p, par, l, r, best, last;
    logic [31:0] prod;
    o = '0;
    if (op == OP_INSERT) begin
      if (count_q >= CAPACITY_DEF) begin
        o.status = ST_FULL;
      end else begin
        p = count_q;
        heap_q[p].key = KEY_W'(hv) + 1'b1;
        heap_q[p].order = seq_q;
        heap_q[p].payload = pl;
        seq_q++;
        count_q++;
        while (p != 0) begin
          par = (p - 1) / 2;
          if (!later(par, p)) break;
          swap_at(p, par);
          p = par;
        end
      end
    end else if (op == OP_REMOVE) begin
      if (count_q == 0) begin
        o.status = ST_EMPTY;
      end else begin
        if (draw < eps_q) begin
          prod = rpos * count_q;
          p = prod >> 16;
          if (p >= count_q) p = count_q - 1;
          heap_q[p].key = '0;
          // forced node climbs unless strictly greater
          while (p != 0) begin
            par = (p - 1) / 2;
            if (later(p, par)) break;
            swap_at(p, par);
            p = par;
          end
          o.rnd = 1'b1;
        end
        o.rvalid = 1'b1;
        o.rpayload = heap_q[0].payload;
        last = count_q - 1;
        if (last != 0) swap_at(0, last);
        count_q = last;
        p = 0;
        forever begin
          l = 2 * p + 1;
          r = l + 1;
          if (l >= last) break;
          best = l;
          if (r < last && later(l, r)) best = r;
          if (!later(p, best)) break;
          swap_at(p, best);
          p = best;
        end
      end
    end else if (op == OP_CLEAR) begin
      count_q = 0;
      seq_q = '0;
    end
    o.occ = OCC_W'(count_q);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e, a;
    if (!rst_ni) begin
      count_q = 0;
      seq_q = '0;
      eps_q = EPS_RESET;
      outcome_fifo.delete();
      errors_o = 0;
      removals_o = 0;
      random_removals_o = 0;
    end else begin
      if (cfg_we_i) eps_q = cfg_wdata_i;
      if (result_valid_i) begin
        a = '{removed_valid_i, removed_payload_i, was_random_i, occupancy_i, status_i};
        if (outcome_fifo.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result transfer: %p", a);
        end else begin
          e = outcome_fifo.pop_front();
          if (a.rvalid) removals_o++;
          if (a.rnd) random_removals_o++;
          if (a !== e) begin
            errors_o++;
            if (errors_o <= 10) $display("mismatch at %0t: expected %p, got %p", $realtime, e, a);
          end
        end
      end
      if (start_i && !busy_i)
        outcome_fifo.push_back(predict_heap_op(op_i, heuristic_value_i, payload_i,
                                               rand_draw_i, rand_pos_i));
    end
    pending_o = outcome_fifo.size();
  end

endmodule

@@ sim/tb_epsilon_greedy_min_heap.sv @@
// testbench top: drives heap commands and epsilon settings, reports the verdict
`timescale 1ns / 1ps
module tb_epsilon_greedy_min_heap;
  import egmh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [1:0]       op_i = OP_CLEAR;
  logic [23:0]      heuristic_value_i = '0;
  logic [31:0]      payload_i = '0;
  logic [15:0]      rand_draw_i = '0;
  logic [15:0]      rand_pos_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [EPS_W-1:0] cfg_wdata_i = '0;
  logic             result_valid_o, removed_valid_o, was_random_o;
  logic [31:0]      removed_payload_o;
  logic [OCC_W-1:0] occupancy_o;
  logic [1:0]       status_o;
  int               errors, pending, removals, random_removals;
  int unsigned      cycles = 0;
  int unsigned      commands = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  epsilon_greedy_min_heap dut (.*);

  egmh_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .heuristic_value_i,
    .payload_i, .rand_draw_i, .rand_pos_i, .cfg_we_i, .cfg_wdata_i,
    .result_valid_i(result_valid_o), .removed_valid_i(removed_valid_o),
    .removed_payload_i(removed_payload_o), .was_random_i(was_random_o),
    .occupancy_i(occupancy_o), .status_i(status_o), .errors_o(errors),
    .pending_o(pending), .removals_o(removals), .random_removals_o(random_removals)
  );

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk_i);
  endtask

  // one command transfer; start stays up across back-to-back commands
  task automatic issue(logic [1:0] op, logic [23:0] hv, logic [31:0] pl,
                       logic [15:0] draw, logic [15:0] rpos, bit gap);
    start_i = 1'b1;
    op_i = op;
    heuristic_value_i = hv;
    payload_i = pl;
    rand_draw_i = draw;
    rand_pos_i = rpos;
    do @(posedge clk_i); while (busy_o);
    commands++;
    @(negedge clk_i);
    if (gap && $urandom_range(0, 2) == 0) begin
      start_i = 1'b0;
      idle_gap();
    end
  endtask

  task automatic settle();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_epsilon(logic [EPS_W-1:0] v);
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_phase(int unsigned n, int unsigned insert_pct);
    logic [1:0]  op;
    logic [23:0] hv;
    repeat (n) begin
      case ($urandom_range(0, 99) < insert_pct ? 0 : ($urandom_range(0, 40) == 0 ? 2 : 1))
        0: op = OP_INSERT;
        1: op = OP_REMOVE;
        default: op = ($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_UNUSED;
      endcase
      // narrow keys force many ties on the key, ordered by insertion
      hv = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 7)) : 24'($urandom);
      issue(op, hv, $urandom, 16'($urandom), 16'($urandom), 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty remove, extremes, unused op, clear
    issue(OP_REMOVE, '0, '0, '0, '0, 1'b0);
    issue(OP_INSERT, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(OP_INSERT, 24'h0, 32'h0, '0, '0, 1'b0);
    issue(OP_INSERT, 24'h5, 32'h55AA55AA, '0, '0, 1'b0);
    issue(OP_INSERT, 24'h5, 32'hAA55AA55, '0, '0, 1'b0);
    issue(OP_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(OP_REMOVE, '0, '0, 16'h0, 16'hFFFF, 1'b0);
    issue(OP_REMOVE, '0, '0, 16'hFFFF, 16'h0, 1'b0);
    issue(OP_REMOVE, '0, '0, 16'h0, 16'h8000, 1'b0);
    issue(OP_CLEAR, '0, '0, '0, '0, 1'b0);
    issue(OP_REMOVE, '0, '0, '0, '0, 1'b0);
    settle();

    // fill to capacity and try two more inserts
    set_epsilon(17'd0);
    for (int i = 0; i < CAPACITY_DEF + 2; i++)
      issue(OP_INSERT, 24'($urandom_range(0, 3)), $urandom, '0, '0, 1'b0);
    issue(OP_REMOVE, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0);
    settle();
    set_epsilon(17'd65536);
    issue(OP_REMOVE, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(OP_REMOVE, '0, '0, 16'h0, 16'h0, 1'b0);
    issue(OP_CLEAR, '0, '0, '0, '0, 1'b0);
    settle();

    set_epsilon(EPS_RESET);
    random_phase(70, 60);
    settle();
    set_epsilon(17'd65535);
    random_phase(60, 55);
    settle();
    set_epsilon(17'd0);
    random_phase(50, 50);
    settle();
    set_epsilon(17'($urandom_range(1, 65536)));
    random_phase(70, 45);
    settle();

    $display("ran %0d commands: %0d removals, %0d on the random path", commands,
             removals, random_removals);
    $display("epsilon covered 0, default, 65535, 65536; full and empty queue exercised");
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
